// ===== hdl/pfts_pkg.sv =====
// shared types and constants for the top-n peak finder
`default_nettype none

package pfts_pkg;

    localparam int TOP_N_DEF     = 10;
    localparam int MAX_FRAME_DEF = 32768;

    localparam int SAMPLE_W = 32;
    localparam int PIDX_W   = 15;

    // one unit of work handed from the front to the sorted list
    typedef struct packed {
        logic                insert;    // value/position is a new peak
        logic                flush;     // frame ends after the insert
        logic [SAMPLE_W-1:0] value;
        logic [PIDX_W-1:0]   position;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/pfts_front.sv =====
// front end: neighbor window, sample counter and peak classification
`default_nettype none

module pfts_front #(
    parameter int MAX_FRAME = pfts_pkg::MAX_FRAME_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pfts_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                          last_sample,
    output logic                               cmd_valid,
    output pfts_pkg::cmd_t                     cmd,
    input  wire logic                          cmd_full
);
    import pfts_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 2);
    localparam logic [CW-1:0] CNT_TWO  = CW'(2);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_FRAME);
    localparam logic [CW-1:0] CNT_SAT  = CW'(MAX_FRAME + 1);

    logic [SAMPLE_W-1:0] older_reg, older_next;
    logic [SAMPLE_W-1:0] middle_reg, middle_next;
    logic [CW-1:0]       count_reg, count_next;

    logic                accept;
    logic                is_peak;
    logic [CW-1:0]       mid_pos;
    logic [CW+PIDX_W-1:0] mid_pos_ext;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && in_ready;

    // middle sample is interior and at least both neighbors
    assign is_peak = (count_reg >= CNT_TWO) && (count_reg <= CNT_MAX) &&
                     (older_reg <= middle_reg) && (middle_reg >= sample);

    assign mid_pos     = count_reg - CW'(1);
    assign mid_pos_ext = {{PIDX_W{1'b0}}, mid_pos};

    always_comb
    begin
        cmd.insert   = is_peak;
        cmd.flush    = last_sample;
        cmd.value    = middle_reg;
        cmd.position = mid_pos_ext[PIDX_W-1:0];
        cmd_valid    = accept && (is_peak || last_sample);
    end

    always_comb
    begin
        older_next  = older_reg;
        middle_next = middle_reg;
        count_next  = count_reg;
        if (accept)
        begin
            if (last_sample)
            begin
                older_next  = '0;
                middle_next = '0;
                count_next  = '0;
            end
            else
            begin
                older_next  = middle_reg;
                middle_next = sample;
                if (count_reg < CNT_SAT)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg  <= '0;
            middle_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            older_reg  <= older_next;
            middle_reg <= middle_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pfts_fifo.sv =====
// short command queue between front end and sorted list
`default_nettype none

module pfts_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pfts_pkg::cmd_t push_cmd,
    output logic                full,
    output logic                pop_valid,
    output pfts_pkg::cmd_t      pop_cmd,
    input  wire logic           pop
);
    import pfts_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    cmd_t          mem [DEPTH];
    logic [AW:0]   wr_reg, wr_next;
    logic [AW:0]   rd_reg, rd_next;
    logic          do_pop;

    assign full      = (wr_reg[AW] != rd_reg[AW]) && (wr_reg[AW-1:0] == rd_reg[AW-1:0]);
    assign pop_valid = (wr_reg != rd_reg);
    assign pop_cmd   = mem[rd_reg[AW-1:0]];
    assign do_pop    = pop && pop_valid;

    assign wr_next = (push && !full) ? wr_reg + (AW+1)'(1) : wr_reg;
    assign rd_next = do_pop ? rd_reg + (AW+1)'(1) : rd_reg;

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_reg[AW-1:0]] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pfts_rank.sv =====
// back end: sorted insertion cells, frame snapshot and result shifter
`default_nettype none

module pfts_rank #(
    parameter int TOP_N = pfts_pkg::TOP_N_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire pfts_pkg::cmd_t                cmd,
    output logic                               cmd_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [pfts_pkg::PIDX_W-1:0]        peak_index,
    output logic [pfts_pkg::SAMPLE_W-1:0]      peak_mag,
    output logic                               peak_valid,
    output logic                               last_result
);
    import pfts_pkg::*;

    localparam int IW = (TOP_N > 1) ? $clog2(TOP_N) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TOP_N - 1);

    // sorted peak list, rank 0 largest
    logic [SAMPLE_W-1:0] val_reg   [TOP_N];
    logic [PIDX_W-1:0]   pos_reg   [TOP_N];
    logic [TOP_N-1:0]    vld_reg;
    logic [SAMPLE_W-1:0] val_next  [TOP_N];
    logic [PIDX_W-1:0]   pos_next  [TOP_N];
    logic [TOP_N-1:0]    vld_next;
    logic [SAMPLE_W-1:0] ins_val   [TOP_N];
    logic [PIDX_W-1:0]   ins_pos   [TOP_N];
    logic [TOP_N-1:0]    ins_vld;
    logic [TOP_N-1:0]    keep;

    // result shifter, entry 0 is the word on the output
    logic [SAMPLE_W-1:0] sv_reg    [TOP_N];
    logic [PIDX_W-1:0]   sp_reg    [TOP_N];
    logic [TOP_N-1:0]    sf_reg;
    logic                busy_reg;
    logic [IW-1:0]       idx_reg;

    logic                take;
    logic                snap;
    logic                shift;

    assign cmd_pop = !(cmd.flush && busy_reg);
    assign take    = cmd_valid && cmd_pop;
    assign snap    = take && cmd.flush;
    assign shift   = busy_reg && out_ready;

    // each cell keeps its entry when it ranks at or above the new value
    always_comb
    begin
        for (int k = 0; k < TOP_N; k++)
        begin
            keep[k] = vld_reg[k] && (val_reg[k] >= cmd.value);
        end
        for (int k = 0; k < TOP_N; k++)
        begin
            if (keep[k] || !cmd.insert)
            begin
                ins_val[k] = val_reg[k];
                ins_pos[k] = pos_reg[k];
                ins_vld[k] = vld_reg[k];
            end
            else if (k == 0 || keep[(k > 0) ? k - 1 : 0])
            begin
                ins_val[k] = cmd.value;
                ins_pos[k] = cmd.position;
                ins_vld[k] = 1'b1;
            end
            else
            begin
                ins_val[k] = val_reg[(k > 0) ? k - 1 : 0];
                ins_pos[k] = pos_reg[(k > 0) ? k - 1 : 0];
                ins_vld[k] = vld_reg[(k > 0) ? k - 1 : 0];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < TOP_N; k++)
        begin
            val_next[k] = val_reg[k];
            pos_next[k] = pos_reg[k];
        end
        vld_next = vld_reg;
        if (take)
        begin
            for (int k = 0; k < TOP_N; k++)
            begin
                val_next[k] = ins_val[k];
                pos_next[k] = ins_pos[k];
            end
            vld_next = cmd.flush ? '0 : ins_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < TOP_N; k++)
        begin
            val_reg[k] <= val_next[k];
            pos_reg[k] <= pos_next[k];
        end
    end

    // snapshot payload, invalid ranks read as zero
    always_ff @(posedge clk)
    begin
        if (snap)
        begin
            for (int k = 0; k < TOP_N; k++)
            begin
                sv_reg[k] <= ins_vld[k] ? ins_val[k] : '0;
                sp_reg[k] <= ins_vld[k] ? ins_pos[k] : '0;
            end
        end
        else if (shift)
        begin
            for (int k = 0; k < TOP_N - 1; k++)
            begin
                sv_reg[k] <= sv_reg[k+1];
                sp_reg[k] <= sp_reg[k+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            sf_reg   <= '0;
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (snap)
            begin
                sf_reg   <= ins_vld;
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (shift)
            begin
                sf_reg <= sf_reg >> 1;
                if (idx_reg == LAST_IDX)
                begin
                    busy_reg <= 1'b0;
                    idx_reg  <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
        end
    end

    assign out_valid   = busy_reg;
    assign peak_index  = sp_reg[0];
    assign peak_mag    = sv_reg[0];
    assign peak_valid  = sf_reg[0];
    assign last_result = (idx_reg == LAST_IDX);

endmodule

`default_nettype wire

// ===== hdl/peak_find_top_n_sort.sv =====
// top level of the top-n spectrum peak finder
`default_nettype none

// Streams one frame of unsigned UQ16.16 spectrum samples, one word per cycle,
// tlast on the final sample. An interior sample that is at least both of its
// neighbors is a peak (every sample of a plateau counts). The TOP_N largest
// peaks are kept sorted by descending value; equal values keep arrival order.
// After the final sample the block sends TOP_N result words, rank 0 first,
// with tlast on the last one; ranks beyond the peaks found carry tuser 0 and
// zero data. Input rate is one sample per cycle while the command queue has
// room: the front end judges the previous sample against both neighbors in
// the same cycle and queues an insert command; the sorted list, all TOP_N
// cells comparing in parallel, takes one command per cycle unless a flush
// waits on the result shifter. Each frame holds the output side for TOP_N
// words plus a gap before the next snapshot, even with tready held high, so a
// steady run of frames of TOP_N samples or fewer stalls the input once the
// four-entry queue fills. Positions beyond MAX_FRAME-1 are not examined.
module peak_find_top_n_sort #(
    parameter int TOP_N     = pfts_pkg::TOP_N_DEF,
    parameter int MAX_FRAME = pfts_pkg::MAX_FRAME_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sample stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] sample
    input  wire logic        s_tlast,   // last_sample
    // result stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [14:0] peak_index, [46:15] peak_mag, [47] zero
    output logic             m_tuser,   // peak_valid
    output logic             m_tlast    // last_result
);
    import pfts_pkg::*;

    logic          push;
    cmd_t          push_cmd;
    logic          full;
    logic          q_valid;
    cmd_t          q_cmd;
    logic          q_pop;
    logic [PIDX_W-1:0]   peak_index;
    logic [SAMPLE_W-1:0] peak_mag;

    // neighbor window and peak test
    pfts_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .sample      (s_tdata),
        .last_sample (s_tlast),
        .cmd_valid   (push),
        .cmd         (push_cmd),
        .cmd_full    (full)
    );

    // decouples sample intake from result delivery
    pfts_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd),
        .pop       (q_pop)
    );

    // sorted list and result output register
    pfts_rank #(
        .TOP_N (TOP_N)
    ) u_rank (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd         (q_cmd),
        .cmd_pop     (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .peak_index  (peak_index),
        .peak_mag    (peak_mag),
        .peak_valid  (m_tuser),
        .last_result (m_tlast)
    );

    assign m_tdata = {1'b0, peak_mag, peak_index};

endmodule

`default_nettype wire

// ===== dv/peak_find_top_n_sort_checker.sv =====
// checker for the top-n peak finder: predicts the ranked peak words and compares them
`default_nettype none

module peak_find_top_n_sort_checker
    import pfts_pkg::*;
#(
    parameter int TOP_N     = TOP_N_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        m_tlast,
    output int               errors,
    output int               pending,
    output int               words_checked
);

    typedef struct {
        logic [PIDX_W-1:0]   index;
        logic [SAMPLE_W-1:0] value;
        logic                valid;
        logic                last;
    } rank_word_t;

    rank_word_t          pending_ranks[$];
    rank_word_t          want;

    logic [SAMPLE_W-1:0] prev2_sample;
    logic [SAMPLE_W-1:0] prev1_sample;
    int unsigned         seen_samples;
    logic [SAMPLE_W-1:0] rank_value[TOP_N];
    logic [PIDX_W-1:0]   rank_pos[TOP_N];
    int                  ranked;

    task automatic clear_frame();
        int k;
        prev2_sample = '0;
        prev1_sample = '0;
        seen_samples = 0;
        ranked       = 0;
        for (k = 0; k < TOP_N; k++)
        begin
            rank_value[k] = '0;
            rank_pos[k]   = '0;
        end
    endtask

    // equal values stay in arrival order: the newcomer goes behind them
    task automatic rank_peak(input logic [SAMPLE_W-1:0] v, input int unsigned pos);
        int slot;
        int k;
        slot = 0;
        while (slot < ranked && rank_value[slot] >= v)
            slot++;
        if (slot < TOP_N)
        begin
            for (k = (ranked < TOP_N) ? ranked : TOP_N - 1; k > slot; k--)
            begin
                rank_value[k] = rank_value[k-1];
                rank_pos[k]   = rank_pos[k-1];
            end
            rank_value[slot] = v;
            rank_pos[slot]   = PIDX_W'(pos);
            if (ranked < TOP_N)
                ranked++;
        end
    endtask

    task automatic absorb_sample(input logic [SAMPLE_W-1:0] s, input logic last);
        int         k;
        rank_word_t w;
        // middle sample judged once its right neighbor is here
        if (seen_samples >= 2 && seen_samples <= MAX_FRAME)
        begin
            if (prev2_sample <= prev1_sample && prev1_sample >= s)
                rank_peak(prev1_sample, seen_samples - 1);
        end
        prev2_sample = prev1_sample;
        prev1_sample = s;
        if (seen_samples < MAX_FRAME + 1)
            seen_samples++;
        if (last)
        begin
            for (k = 0; k < TOP_N; k++)
            begin
                w.valid = (k < ranked);
                w.index = w.valid ? rank_pos[k] : '0;
                w.value = w.valid ? rank_value[k] : '0;
                w.last  = (k == TOP_N - 1);
                pending_ranks.push_back(w);
            end
            clear_frame();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            pending_ranks.delete();
            pending       <= 0;
            words_checked <= 0;
            errors = 0;
        end
        else
        begin
            // results first: a word leaving now belongs to an earlier frame
            if (m_tvalid && m_tready)
            begin
                if (pending_ranks.size() == 0)
                begin
                    errors++;
                    $error("result word with nothing expected: tdata %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    want = pending_ranks.pop_front();
                    if (m_tdata[14:0] !== want.index)
                    begin
                        errors++;
                        $error("peak_index: expected %0d, got %0d", want.index, m_tdata[14:0]);
                    end
                    if (m_tdata[46:15] !== want.value)
                    begin
                        errors++;
                        $error("peak_mag: expected %h, got %h", want.value, m_tdata[46:15]);
                    end
                    if (m_tuser !== want.valid)
                    begin
                        errors++;
                        $error("peak_valid: expected %b, got %b", want.valid, m_tuser);
                    end
                    if (m_tlast !== want.last)
                    begin
                        errors++;
                        $error("last_result: expected %b, got %b", want.last, m_tlast);
                    end
                    if (m_tdata[47] !== 1'b0)
                    begin
                        errors++;
                        $error("pad: expected 0, got %b", m_tdata[47]);
                    end
                end
                words_checked <= words_checked + 1;
            end
            if (s_tvalid && s_tready)
                absorb_sample(s_tdata, s_tlast);
            pending <= pending_ranks.size();
        end
    end

endmodule

`default_nettype wire

// ===== dv/peak_find_top_n_sort_tb.sv =====
// testbench top for the top-n peak finder: stimulus, flow control and verdict
`default_nettype none

module peak_find_top_n_sort_tb;

    localparam int IDLE_LIMIT     = 5000;   // cycles with no word moving on either side
    localparam int RANDOM_SAMPLES = 380;
    localparam int MAX_GAP        = 6;
    localparam int DRAIN_TAIL     = 20;     // settle cycles after the last result

    // content patterns for random frames
    typedef enum int {
        SHAPE_FULL,      // any 32-bit value
        SHAPE_LEVELS,    // few levels: plateaus and ties everywhere
        SHAPE_ZIGZAG,    // alternating low/high: many peaks, list overflows
        SHAPE_EXTREME    // values at the ends of the range
    } frame_shape_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int          errors;
    int          pending;
    int          words_checked;

    // idle switches, one per side; set per frame from the stimulus
    logic        tx_quiet = 1'b0;
    logic        rx_quiet = 1'b0;

    int          samples_sent = 0;
    int          frames_sent  = 0;

    peak_find_top_n_sort dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    peak_find_top_n_sort_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .errors        (errors),
        .pending       (pending),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // push one sample word: random gap first, then hold until accepted
    task automatic send_word(input logic [31:0] sample, input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= sample;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        samples_sent++;
        if (last)
            frames_sent++;
    endtask

    // stop sending and wait until every ranked word of earlier frames is out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] draw_sample(input frame_shape_t shape, input int pos);
        logic [31:0] v;
        case (shape)
            SHAPE_LEVELS:  v = $urandom_range(0, 3);
            SHAPE_ZIGZAG:  v = pos[0] ? ($urandom | 32'h8000_0000) : ($urandom & 32'h0000_ffff);
            SHAPE_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h0000_0001;
                    2:       v = 32'hffff_fffe;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default:       v = $urandom;
        endcase
        return v;
    endfunction

    // result side: random stall before each word, then ready until it moves
    initial
    begin : result_sink
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    // watchdog: too long without any word moving means a hang
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int           i;
        int           len;
        int           random_done;
        frame_shape_t shape;

        // single reset pulse at the start of the run
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed frames ----
        // one-sample frame: no interior sample, every rank invalid
        send_word(32'hffff_ffff, 1'b1);
        // two-sample frame: still no interior sample
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h0000_0007, 1'b1);
        // single peak at full scale between zeros; the other ranks are missing
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hffff_ffff, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        // plateau: every flat sample counts, ties keep arrival order
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0004, 1'b0);
        send_word(32'h0000_0004, 1'b0);
        send_word(32'h0000_0004, 1'b0);
        send_word(32'h0000_0002, 1'b1);
        drain_results();
        // long plateau fills the list, the eleventh tie is dropped,
        // then a taller peak pushes the last entry out
        for (i = 0; i < 13; i++)
            send_word(32'h0001_0000, 1'b0);
        send_word(32'h0002_0000, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        drain_results();

        // ---- random frames ----
        random_done = 0;
        while (random_done < RANDOM_SAMPLES)
        begin
            // about a quarter of the frames run without gaps on a side
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            shape    = frame_shape_t'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, 2);
            else
                len = $urandom_range(3, 40);
            for (i = 0; i < len; i++)
                send_word(draw_sample(shape, i), i == len - 1);
            random_done += len;
            // now and then hold off until the ranking of every frame is out
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end

        // ---- wind down ----
        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("run covered %0d samples in %0d frames: short, plateau, list-overflow",
                 samples_sent, frames_sent);
        $display("and random frames; %0d result words compared", words_checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/pfts_pkg.sv
hdl/pfts_front.sv
hdl/pfts_fifo.sv
hdl/pfts_rank.sv
hdl/peak_find_top_n_sort.sv
dv/peak_find_top_n_sort_checker.sv
dv/peak_find_top_n_sort_tb.sv
